### hw/rtl/lsv_pkg.sv
// Shared types and constants of the looping sample voice.
// Holds beat layouts, mode codes, register indexes, reset values and gain constants; depends on nothing.
`default_nettype none

package lsv_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] MODE_LOAD    = 2'd0;
   localparam logic [1:0] MODE_RESTART = 2'd1;
   localparam logic [1:0] MODE_TICK    = 2'd2;

   localparam logic [2:0] REG_LOOP_ON      = 3'd0;
   localparam logic [2:0] REG_LOOP_START   = 3'd1;
   localparam logic [2:0] REG_LOOP_END     = 3'd2;
   localparam logic [2:0] REG_SOUND_LENGTH = 3'd3;
   localparam logic [2:0] REG_PITCH_STEP   = 3'd4;
   localparam logic [2:0] REG_VOICE_GAIN   = 3'd5;
   localparam logic [2:0] REG_PAN_POSITION = 3'd6;
   localparam logic [2:0] REG_MASTER_GAIN  = 3'd7;

   localparam logic [16:0] LOOP_END_RESET    = 17'h10000;
   localparam logic [19:0] PITCH_STEP_RESET  = 20'h10000;
   localparam logic [15:0] VOICE_GAIN_RESET  = 16'h8000;
   localparam logic [15:0] MASTER_GAIN_RESET = 16'h8000;

   localparam logic [15:0] GAIN_UNITY = 16'h8000;
   localparam int          GAIN_SHIFT = 30;

   typedef struct packed {
      logic [15:0] right_in;
      logic [15:0] left_in;
      logic [15:0] sample_value;
      logic [15:0] sample_addr;
   } req_beat_type;

   typedef struct packed {
      logic [6:0]  pad;
      logic        still_playing;
      logic [15:0] right_out;
      logic [15:0] left_out;
   } rsp_beat_type;

endpackage

`default_nettype wire

### hw/rtl/looping_sample_voice.sv
// Top level of the looping sample voice: register file, tick sequencer,
// shared multiplier and loop modulo unit. Uses lsv_pkg and lsv_ram.
//
//  channel | direction | beat contents
//  req_    | in        | tuser: mode; tdata: sample_addr, sample_value, left_in, right_in
//  rsp_    | out       | tdata: left_out, right_out, still_playing (ticks only)
//  csr_    | in/out    | APB register file, eight registers at byte address 4*i
//
// Load, restart and unused beats leave the sequencer idle. A tick runs eleven sequencer
// steps around one shared multiplier, then a result step and a return to idle. A tick
// that wraps the loop also waits in the result step for the bit-serial modulo unit.
// An ended voice or an empty sound goes from the index step straight to the result step.
// Synchronous reset clears the control state; the sample store is not cleared.
// The next beat is accepted while a result still waits in the output register.
`default_nettype none

module looping_sample_voice #(
   parameter int SAMPLE_DEPTH = 65536,
   parameter int SAMPLE_BITS  = 16,
   parameter int FRAC_BITS    = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // tdata: sample_addr, sample_value, left_in, right_in
   input  wire logic [63:0]                    req_tdata,
   // tuser: mode
   input  wire logic [1:0]                     req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // tdata: left_out, right_out, still_playing, zero pad
   output logic [39:0]                         rsp_tdata,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [lsv_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [lsv_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [lsv_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);

   import lsv_pkg::*;

   localparam int POS_W   = 17 + FRAC_BITS;
   localparam int AW      = $clog2(SAMPLE_DEPTH);
   localparam int VAL_W   = SAMPLE_BITS + FRAC_BITS + 1;
   localparam int MAW     = (VAL_W > 33) ? VAL_W : 33;
   localparam int MBW     = ((FRAC_BITS + 1 > 16) ? FRAC_BITS + 1 : 16) + 1;
   localparam int PW      = MAW + MBW;
   localparam int DIV_W   = POS_W + 1 - FRAC_BITS;
   localparam int CNT_W   = $clog2(DIV_W + 1);
   localparam int C_SHIFT = SAMPLE_BITS - 1 + FRAC_BITS;

   localparam logic [POS_W-1:0]       POS_MAX = {POS_W{1'b1}};
   localparam logic [FRAC_BITS:0]     FX_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [PW-1:0]   C_HALF  = PW'(1) << (C_SHIFT - 1);
   localparam logic [48:0]            G_HALF  = 49'(1) << (GAIN_SHIFT - 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_IDX  = 4'd1;
   localparam logic [3:0] S_G0   = 4'd2;
   localparam logic [3:0] S_G1   = 4'd3;
   localparam logic [3:0] S_G2   = 4'd4;
   localparam logic [3:0] S_G3   = 4'd5;
   localparam logic [3:0] S_I0   = 4'd6;
   localparam logic [3:0] S_I1   = 4'd7;
   localparam logic [3:0] S_I2   = 4'd8;
   localparam logic [3:0] S_C0   = 4'd9;
   localparam logic [3:0] S_C1   = 4'd10;
   localparam logic [3:0] S_C2   = 4'd11;
   localparam logic [3:0] S_DONE = 4'd12;

   function automatic logic [15:0] pan_factor(input logic signed [17:0] f);
      if (f <= 18'sd0) begin
         return 16'd0;
      end else if (f > 18'sd32768) begin
         return GAIN_UNITY;
      end
      return f[15:0];
   endfunction

   function automatic logic [15:0] gain_round(input logic [48:0] g);
      logic [18:0] r;
      r = 19'((g + G_HALF) >> GAIN_SHIFT);
      return (r > 19'(GAIN_UNITY)) ? GAIN_UNITY : r[15:0];
   endfunction

   function automatic logic [15:0] sat16(input logic signed [18:0] v);
      if (v > 19'sd32767) begin
         return 16'h7FFF;
      end else if (v < -19'sd32768) begin
         return 16'h8000;
      end
      return v[15:0];
   endfunction

   // Registers.
   logic [3:0]              state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_beat_type            rsp_beat_ff, rsp_beat_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic                    loop_on_ff, loop_on_in;
   logic [15:0]             loop_start_ff, loop_start_in;
   logic [16:0]             loop_end_ff, loop_end_in;
   logic [16:0]             sound_length_ff, sound_length_in;
   logic [19:0]             pitch_step_ff, pitch_step_in;
   logic [15:0]             voice_gain_ff, voice_gain_in;
   logic signed [16:0]      pan_position_ff, pan_position_in;
   logic [15:0]             master_gain_ff, master_gain_in;
   logic signed [15:0]      acc_left_ff, acc_left_in;
   logic signed [15:0]      acc_right_ff, acc_right_in;
   logic [16:0]             idx0_ff, idx0_in;
   logic [16:0]             idx1_ff, idx1_in;
   logic [FRAC_BITS-1:0]    frac_ff, frac_in;
   logic [POS_W:0]          np_ff, np_in;
   logic                    pass_ff, pass_in;
   logic                    wrap_ff, wrap_in;
   logic signed [SAMPLE_BITS-1:0] s0_ff, s0_in;
   logic signed [SAMPLE_BITS-1:0] s1_ff, s1_in;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic [15:0]             gl_ff, gl_in;
   logic [15:0]             gr_ff, gr_in;
   logic signed [VAL_W-1:0] part_ff, part_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic [15:0]             mix_left_ff, mix_left_in;
   logic [15:0]             mix_right_ff, mix_right_in;
   logic [CNT_W-1:0]        div_cnt_ff, div_cnt_in;
   logic [DIV_W-1:0]        div_num_ff, div_num_in;
   logic [DIV_W-1:0]        div_rem_ff, div_rem_in;
   logic [FRAC_BITS-1:0]    div_low_ff, div_low_in;

   // Combinational signals.
   req_beat_type            req_beat;
   logic                    req_fire;
   logic                    csr_wr;
   logic [16:0]             len;
   logic [16:0]             last;
   logic [16:0]             loop_len;
   logic                    looping;
   logic [16:0]             hp;
   logic [17:0]             h1;
   logic [17:0]             wrap_idx0;
   logic [17:0]             wrap_idx1;
   logic                    pass_now;
   logic [POS_W:0]          le_full;
   logic [POS_W:0]          d_full;
   logic [DIV_W-1:0]        rem_sh;
   logic [15:0]             pfl;
   logic [15:0]             pfr;
   logic [FRAC_BITS:0]      w0;
   logic signed [MAW-1:0]   mul_a;
   logic signed [MBW-1:0]   mul_b;
   logic signed [PW-1:0]    c_sum;
   logic signed [17:0]      c_val;
   logic                    done_go;
   logic [POS_W-1:0]        pos_next;
   logic                    play_now;
   logic                    ram_wr_en;
   logic [AW-1:0]           ram_rd_addr;
   logic [SAMPLE_BITS-1:0]  ram_rd_data;

   assign req_beat   = req_tdata;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_beat_ff;

   assign len      = (32'(sound_length_ff) > 32'(SAMPLE_DEPTH)) ? 17'(SAMPLE_DEPTH)
                                                               : sound_length_ff;
   assign last     = len - 17'd1;
   assign loop_len = loop_end_ff - {1'b0, loop_start_ff};
   assign looping  = loop_on_ff && (loop_end_ff > {1'b0, loop_start_ff});

   assign hp        = pos_ff[POS_W-1:FRAC_BITS];
   assign h1        = {1'b0, hp} + 18'd1;
   assign wrap_idx0 = (looping && hp >= loop_end_ff) ? {1'b0, hp - loop_len} : {1'b0, hp};
   assign wrap_idx1 = (looping && h1 >= {1'b0, loop_end_ff}) ? h1 - {1'b0, loop_len} : h1;
   assign pass_now  = (len == 17'd0) || (!looping && hp >= len);

   assign le_full = {1'b0, loop_end_ff, {FRAC_BITS{1'b0}}};
   assign d_full  = np_ff - le_full;
   assign rem_sh  = {div_rem_ff[DIV_W-2:0], div_num_ff[DIV_W-1]};

   assign pfl = pan_factor(18'sd32768 - 18'(pan_position_ff));
   assign pfr = pan_factor(18'sd32768 + 18'(pan_position_ff));
   assign w0  = FX_ONE - (FRAC_BITS + 1)'(frac_ff);

   assign c_sum = prod_ff + C_HALF;
   assign c_val = 18'(c_sum >>> C_SHIFT);

   assign done_go = (state_ff == S_DONE) && (div_cnt_ff == '0) &&
                    (!rsp_valid_ff || rsp_tready);

   always_comb begin
      if (wrap_ff) begin
         pos_next = {17'({1'b0, loop_start_ff} + div_rem_ff[16:0]), div_low_ff};
      end else if (np_ff[POS_W]) begin
         pos_next = POS_MAX;
      end else begin
         pos_next = np_ff[POS_W-1:0];
      end
      if (pass_ff) begin
         play_now = 1'b0;
      end else if (looping) begin
         play_now = 1'b1;
      end else begin
         play_now = np_ff < {1'b0, len, {FRAC_BITS{1'b0}}};
      end
   end

   assign ram_wr_en   = req_fire && (req_tuser == MODE_LOAD) &&
                        (32'(req_beat.sample_addr) < 32'(SAMPLE_DEPTH));
   assign ram_rd_addr = (state_ff == S_G0) ? AW'(idx0_ff) : AW'(idx1_ff);

   lsv_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (SAMPLE_DEPTH)
   ) u_sample_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (AW'(req_beat.sample_addr)),
      .wr_data (SAMPLE_BITS'(req_beat.sample_value)),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      case (csr_paddr[4:2])
         REG_LOOP_ON:      csr_prdata = 32'(loop_on_ff);
         REG_LOOP_START:   csr_prdata = 32'(loop_start_ff);
         REG_LOOP_END:     csr_prdata = 32'(loop_end_ff);
         REG_SOUND_LENGTH: csr_prdata = 32'(sound_length_ff);
         REG_PITCH_STEP:   csr_prdata = 32'(pitch_step_ff);
         REG_VOICE_GAIN:   csr_prdata = 32'(voice_gain_ff);
         REG_PAN_POSITION: csr_prdata = 32'(unsigned'(pan_position_ff));
         REG_MASTER_GAIN:  csr_prdata = 32'(master_gain_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_beat_in     = rsp_beat_ff;
      pos_in          = pos_ff;
      loop_on_in      = loop_on_ff;
      loop_start_in   = loop_start_ff;
      loop_end_in     = loop_end_ff;
      sound_length_in = sound_length_ff;
      pitch_step_in   = pitch_step_ff;
      voice_gain_in   = voice_gain_ff;
      pan_position_in = pan_position_ff;
      master_gain_in  = master_gain_ff;
      acc_left_in     = acc_left_ff;
      acc_right_in    = acc_right_ff;
      idx0_in         = idx0_ff;
      idx1_in         = idx1_ff;
      frac_in         = frac_ff;
      np_in           = np_ff;
      pass_in         = pass_ff;
      wrap_in         = wrap_ff;
      s0_in           = s0_ff;
      s1_in           = s1_ff;
      gl_in           = gl_ff;
      gr_in           = gr_ff;
      part_in         = part_ff;
      value_in        = value_ff;
      mix_left_in     = mix_left_ff;
      mix_right_in    = mix_right_ff;
      div_cnt_in      = div_cnt_ff;
      div_num_in      = div_num_ff;
      div_rem_in      = div_rem_ff;
      div_low_in      = div_low_ff;
      mul_a           = '0;
      mul_b           = '0;

      if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_LOOP_ON:      loop_on_in      = csr_pwdata[0];
            REG_LOOP_START:   loop_start_in   = csr_pwdata[15:0];
            REG_LOOP_END:     loop_end_in     = csr_pwdata[16:0];
            REG_SOUND_LENGTH: sound_length_in = csr_pwdata[16:0];
            REG_PITCH_STEP:   pitch_step_in   = csr_pwdata[19:0];
            REG_VOICE_GAIN:   voice_gain_in   = csr_pwdata[15:0];
            REG_PAN_POSITION: pan_position_in = signed'(csr_pwdata[16:0]);
            REG_MASTER_GAIN:  master_gain_in  = csr_pwdata[15:0];
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // One restoring step of the loop modulo per cycle.
      if (div_cnt_ff != '0) begin
         div_cnt_in = div_cnt_ff - CNT_W'(1);
         div_num_in = div_num_ff << 1;
         if (rem_sh >= DIV_W'(loop_len)) begin
            div_rem_in = rem_sh - DIV_W'(loop_len);
         end else begin
            div_rem_in = rem_sh;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  MODE_RESTART: pos_in = '0;
                  MODE_TICK: begin
                     acc_left_in  = signed'(req_beat.left_in);
                     acc_right_in = signed'(req_beat.right_in);
                     state_in     = S_IDX;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_IDX: begin
            idx0_in      = (wrap_idx0 > {1'b0, last}) ? last : wrap_idx0[16:0];
            idx1_in      = (wrap_idx1 > {1'b0, last}) ? last : wrap_idx1[16:0];
            frac_in      = pos_ff[FRAC_BITS-1:0];
            np_in        = {1'b0, pos_ff} + (POS_W + 1)'(pitch_step_ff);
            pass_in      = pass_now;
            wrap_in      = 1'b0;
            mix_left_in  = acc_left_ff;
            mix_right_in = acc_right_ff;
            state_in     = pass_now ? S_DONE : S_G0;
         end
         S_G0: begin
            mul_a      = MAW'($signed({1'b0, pfl}));
            mul_b      = MBW'($signed({1'b0, voice_gain_ff}));
            wrap_in    = looping && (np_ff >= le_full);
            div_num_in = d_full[POS_W:FRAC_BITS];
            div_low_in = d_full[FRAC_BITS-1:0];
            div_rem_in = '0;
            div_cnt_in = (looping && (np_ff >= le_full)) ? CNT_W'(DIV_W) : '0;
            state_in   = S_G1;
         end
         S_G1: begin
            s0_in    = signed'(ram_rd_data);
            mul_a    = MAW'($signed({1'b0, prod_ff[31:0]}));
            mul_b    = MBW'($signed({1'b0, master_gain_ff}));
            state_in = S_G2;
         end
         S_G2: begin
            s1_in    = signed'(ram_rd_data);
            gl_in    = gain_round(prod_ff[48:0]);
            mul_a    = MAW'($signed({1'b0, pfr}));
            mul_b    = MBW'($signed({1'b0, voice_gain_ff}));
            state_in = S_G3;
         end
         S_G3: begin
            mul_a    = MAW'($signed({1'b0, prod_ff[31:0]}));
            mul_b    = MBW'($signed({1'b0, master_gain_ff}));
            state_in = S_I0;
         end
         S_I0: begin
            gr_in    = gain_round(prod_ff[48:0]);
            mul_a    = MAW'(s0_ff);
            mul_b    = MBW'($signed({1'b0, w0}));
            state_in = S_I1;
         end
         S_I1: begin
            part_in  = VAL_W'(prod_ff);
            mul_a    = MAW'(s1_ff);
            mul_b    = MBW'($signed({1'b0, frac_ff}));
            state_in = S_I2;
         end
         S_I2: begin
            value_in = VAL_W'(part_ff + VAL_W'(prod_ff));
            state_in = S_C0;
         end
         S_C0: begin
            mul_a    = MAW'(value_ff);
            mul_b    = MBW'($signed({1'b0, gl_ff}));
            state_in = S_C1;
         end
         S_C1: begin
            mix_left_in = sat16(19'(acc_left_ff) + 19'(c_val));
            mul_a       = MAW'(value_ff);
            mul_b       = MBW'($signed({1'b0, gr_ff}));
            state_in    = S_C2;
         end
         S_C2: begin
            mix_right_in = sat16(19'(acc_right_ff) + 19'(c_val));
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (done_go) begin
               rsp_valid_in               = 1'b1;
               rsp_beat_in.pad            = '0;
               rsp_beat_in.still_playing  = play_now;
               rsp_beat_in.right_out      = mix_right_ff;
               rsp_beat_in.left_out       = mix_left_ff;
               if (!pass_ff) begin
                  pos_in = pos_next;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         pos_ff          <= '0;
         div_cnt_ff      <= '0;
         loop_on_ff      <= 1'b0;
         loop_start_ff   <= '0;
         loop_end_ff     <= LOOP_END_RESET;
         sound_length_ff <= '0;
         pitch_step_ff   <= PITCH_STEP_RESET;
         voice_gain_ff   <= VOICE_GAIN_RESET;
         pan_position_ff <= '0;
         master_gain_ff  <= MASTER_GAIN_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         pos_ff          <= pos_in;
         div_cnt_ff      <= div_cnt_in;
         loop_on_ff      <= loop_on_in;
         loop_start_ff   <= loop_start_in;
         loop_end_ff     <= loop_end_in;
         sound_length_ff <= sound_length_in;
         pitch_step_ff   <= pitch_step_in;
         voice_gain_ff   <= voice_gain_in;
         pan_position_ff <= pan_position_in;
         master_gain_ff  <= master_gain_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff  <= rsp_beat_in;
      acc_left_ff  <= acc_left_in;
      acc_right_ff <= acc_right_in;
      idx0_ff      <= idx0_in;
      idx1_ff      <= idx1_in;
      frac_ff      <= frac_in;
      np_ff        <= np_in;
      pass_ff      <= pass_in;
      wrap_ff      <= wrap_in;
      s0_ff        <= s0_in;
      s1_ff        <= s1_in;
      prod_ff      <= prod_in;
      gl_ff        <= gl_in;
      gr_ff        <= gr_in;
      part_ff      <= part_in;
      value_ff     <= value_in;
      mix_left_ff  <= mix_left_in;
      mix_right_ff <= mix_right_in;
      div_num_ff   <= div_num_in;
      div_rem_ff   <= div_rem_in;
      div_low_ff   <= div_low_in;
   end

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (div_cnt_ff == '0))
      else $error("modulo unit busy while the voice is idle");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_G0) |-> ((idx0_ff < len) && (idx1_ff < len)))
      else $error("sample read index outside the sound");

   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      done_go |=> rsp_valid_ff)
      else $error("finished tick did not present a result beat");

   a_wrap_pos: assert property (@(posedge clock) disable iff (reset)
      (done_go && wrap_ff && !pass_ff) |=> ({1'b0, pos_ff} < le_full))
      else $error("wrapped play position not inside the loop");

endmodule

`default_nettype wire

### hw/rtl/lsv_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the sample store of the looping sample voice; no dependencies.
`default_nettype none

module lsv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### verif/looping_sample_voice_tb.sv
// Self-checking testbench for the looping sample voice: directed and random beats,
// with an interpolating, panning and saturating mix predictor held in a scoreboard.
// Depends on lsv_pkg and looping_sample_voice.
`default_nettype none

module looping_sample_voice_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lsv_pkg::*;

   localparam logic [1:0]      MODE_UNUSED = 2'd3;
   localparam longint unsigned POS_MAX     = (64'd1 << 33) - 64'd1;
   localparam longint          GAIN_HALF   = 64'sd1 << 29;
   localparam longint          MIX_HALF    = 64'sd1 << 30;
   localparam int              DRAIN_WAIT  = 40;
   localparam int              CYCLE_LIMIT = 400000;

   typedef struct {
      int loop_on;
      int loop_start;
      int loop_end;
      int sound_length;
      int pitch_step;
      int voice_gain;
      int pan_position;
      int master_gain;
   } voice_setup_type;

   class voice_scoreboard_type;
      logic signed [15:0] store [65536];
      bit                 loaded [65536];
      longint unsigned    position;
      longint unsigned    loop_on, loop_start, loop_end, sound_length, pitch_step;
      longint unsigned    voice_gain, master_gain;
      longint             pan_position;
      rsp_beat_type       expected_mix [$];
      int                 errors;

      function new();
         position     = 0;
         loop_on      = 0;
         loop_start   = 0;
         loop_end     = 65536;
         sound_length = 0;
         pitch_step   = 65536;
         voice_gain   = 32768;
         pan_position = 0;
         master_gain  = 32768;
         errors       = 0;
      endfunction

      function void set_reg(logic [2:0] index, logic [31:0] value);
         case (index)
            REG_LOOP_ON:      loop_on      = value[0];
            REG_LOOP_START:   loop_start   = value[15:0];
            REG_LOOP_END:     loop_end     = value[16:0];
            REG_SOUND_LENGTH: sound_length = value[16:0];
            REG_PITCH_STEP:   pitch_step   = value[19:0];
            REG_VOICE_GAIN:   voice_gain   = value[15:0];
            REG_PAN_POSITION: pan_position = longint'(signed'(value[16:0]));
            REG_MASTER_GAIN:  master_gain  = value[15:0];
            default: ;
         endcase
      endfunction

      // Works out the two read points, the fraction and the next position of a tick.
      // Returns 0 when the voice only passes the accumulators through.
      function bit plan_tick(output longint unsigned idx0, output longint unsigned idx1,
                             output longint unsigned frac, output longint unsigned next_pos,
                             output bit playing);
         longint unsigned len, le, ll, p0, p1, np;
         bit looping;
         len      = (sound_length > 65536) ? 65536 : sound_length;
         looping  = (loop_on != 0) && (loop_end > loop_start);
         idx0     = 0;
         idx1     = 0;
         frac     = 0;
         next_pos = position;
         playing  = 1'b0;
         if (len == 0 || (!looping && position >= (len << 16)))
            return 1'b0;
         if (looping) begin
            le = loop_end << 16;
            ll = (loop_end - loop_start) << 16;
            p0 = position;
            p1 = position + 65536;
            if (p0 >= le) p0 = p0 - ll;
            if (p1 >= le) p1 = p1 - ll;
            np = position + pitch_step;
            if (np >= le) np = le - ll + ((np - le) % ll);
            idx1 = p1 >> 16;
         end else begin
            p0   = position;
            np   = position + pitch_step;
            idx1 = (p0 >> 16) + 1;
         end
         idx0 = p0 >> 16;
         if (np > POS_MAX) np = POS_MAX;
         frac = p0 & 64'hFFFF;
         if (idx0 > len - 1) idx0 = len - 1;
         if (idx1 > len - 1) idx1 = len - 1;
         next_pos = np;
         playing  = looping || (np < (len << 16));
         return 1'b1;
      endfunction

      function longint side_gain(longint pan_factor);
         longint g;
         if (pan_factor > 32768) pan_factor = 32768;
         g = longint'(voice_gain) * pan_factor * longint'(master_gain);
         if (g <= 0)
            return 0;
         g = (g + GAIN_HALF) >>> 30;
         return (g > 32768) ? 64'sd32768 : g;
      endfunction

      function logic [15:0] clip16(longint v);
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         return v[15:0];
      endfunction

      function void note_beat(logic [1:0] mode, req_beat_type beat);
         longint unsigned i0, i1, fr, np;
         bit              playing;
         longint          interp, gl, gr, cl, cr;
         rsp_beat_type    mix;
         case (mode)
            MODE_LOAD: begin
               store[beat.sample_addr]  = beat.sample_value;
               loaded[beat.sample_addr] = 1'b1;
            end
            MODE_RESTART: position = 0;
            MODE_TICK: begin
               mix = '0;
               if (plan_tick(i0, i1, fr, np, playing)) begin
                  interp = longint'(store[i0]) * longint'(65536 - fr)
                         + longint'(store[i1]) * longint'(fr);
                  gl = side_gain(32768 - pan_position);
                  gr = side_gain(32768 + pan_position);
                  cl = (interp * gl + MIX_HALF) >>> 31;
                  cr = (interp * gr + MIX_HALF) >>> 31;
                  mix.left_out      = clip16(longint'($signed(beat.left_in)) + cl);
                  mix.right_out     = clip16(longint'($signed(beat.right_in)) + cr);
                  mix.still_playing = playing;
                  position          = np;
               end else begin
                  mix.left_out  = beat.left_in;
                  mix.right_out = beat.right_in;
               end
               expected_mix = {expected_mix, mix};
            end
            default: ;
         endcase
      endfunction

      function void check_beat(logic [39:0] data);
         rsp_beat_type got, want;
         got = data;
         if (expected_mix.size() == 0) begin
            $display("%0t: result beat %h arrived with nothing expected", $time, data);
            errors++;
         end else begin
            want = expected_mix.pop_front();
            if (got.left_out !== want.left_out) begin
               $display("%0t: left_out expected %0d, got %0d", $time,
                        $signed(want.left_out), $signed(got.left_out));
               errors++;
            end
            if (got.right_out !== want.right_out) begin
               $display("%0t: right_out expected %0d, got %0d", $time,
                        $signed(want.right_out), $signed(got.right_out));
               errors++;
            end
            if (got.still_playing !== want.still_playing) begin
               $display("%0t: still_playing expected %b, got %b", $time,
                        want.still_playing, got.still_playing);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata   = '0;   // sample_addr, sample_value, left_in, right_in
   logic [1:0]  req_tuser   = '0;   // mode
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [39:0] rsp_tdata;          // left_out, right_out, still_playing, zero pad
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr  = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   voice_scoreboard_type sb;
   bit              quiet = 1'b0;
   int              beats_sent = 0;
   int              cycles = 0;

   looping_sample_voice dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_beat(rsp_tdata);
   end

   initial begin
      int stall;
      forever begin
         stall = quiet ? 0 : int'($urandom_range(0, 5));
         repeat (stall) begin
            @(negedge clock);
            rsp_tready = 1'b0;
         end
         @(negedge clock);
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   function automatic logic [15:0] draw_word();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int pick(int lo, int hi);
      case ($urandom_range(0, 7))
         0:       return lo;
         1:       return hi;
         default: return lo + int'($urandom_range(0, hi - lo));
      endcase
   endfunction

   // Every task below is entered and left at a falling clock edge.
   task automatic send_beat(input logic [1:0] mode, input logic [15:0] addr,
                            input logic [15:0] value, input logic [15:0] lin,
                            input logic [15:0] rin);
      req_beat_type beat;
      int           gap;
      beat.sample_addr  = addr;
      beat.sample_value = value;
      beat.left_in      = lin;
      beat.right_in     = rin;
      gap = quiet ? 0 : int'($urandom_range(0, 5));
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = beat;
      req_tuser  = mode;
      do @(posedge clock); while (!req_tready);
      sb.note_beat(mode, beat);
      if (mode != MODE_UNUSED) beats_sent++;
      @(negedge clock);
   endtask

   // The store is loaded at any read point that was never written before the tick goes.
   task automatic send_tick(input logic [15:0] lin, input logic [15:0] rin);
      longint unsigned i0, i1, fr, np;
      bit              playing;
      if (sb.plan_tick(i0, i1, fr, np, playing)) begin
         if (!sb.loaded[i0])
            send_beat(MODE_LOAD, i0[15:0], draw_word(), draw_word(), draw_word());
         if (!sb.loaded[i1])
            send_beat(MODE_LOAD, i1[15:0], draw_word(), draw_word(), draw_word());
      end
      send_beat(MODE_TICK, 16'($urandom), 16'($urandom), lin, rin);
   endtask

   task automatic settle();
      req_tvalid = 1'b0;
      while (sb.expected_mix.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(index, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic program_voice(input voice_setup_type s);
      settle();
      write_reg(REG_LOOP_ON,      32'(s.loop_on));
      write_reg(REG_LOOP_START,   32'(s.loop_start));
      write_reg(REG_LOOP_END,     32'(s.loop_end));
      write_reg(REG_SOUND_LENGTH, 32'(s.sound_length));
      write_reg(REG_PITCH_STEP,   32'(s.pitch_step));
      write_reg(REG_VOICE_GAIN,   32'(s.voice_gain));
      write_reg(REG_PAN_POSITION, 32'(s.pan_position) & 32'h1FFFF);
      write_reg(REG_MASTER_GAIN,  32'(s.master_gain));
   endtask

   function automatic voice_setup_type draw_setup();
      voice_setup_type s;
      int r, span;
      r = int'($urandom_range(0, 9));
      if (r == 0)      s.sound_length = 0;
      else if (r == 1) s.sound_length = 65536;
      else if (r == 2) s.sound_length = int'($urandom_range(1, 65536));
      else             s.sound_length = int'($urandom_range(1, 40));
      s.loop_on = ($urandom_range(0, 3) != 0) ? 1 : 0;
      span = (s.sound_length == 0 || s.sound_length > 64) ? 40 : s.sound_length;
      r = int'($urandom_range(0, 9));
      if (r == 0) begin
         s.loop_start = 0;
         s.loop_end   = 65536;
      end else if (r == 1) begin
         s.loop_start = 65535;
         s.loop_end   = 65536;
      end else if (r == 2) begin
         s.loop_start = int'($urandom_range(1, 65535));
         s.loop_end   = int'($urandom_range(1, s.loop_start));
      end else begin
         s.loop_start = int'($urandom_range(0, span - 1));
         s.loop_end   = int'($urandom_range(s.loop_start + 1, span + 2));
      end
      r = int'($urandom_range(0, 3));
      s.pitch_step   = (r == 0) ? pick(0, 524288) : pick(0, 3 * 65536);
      s.voice_gain   = pick(0, 65535);
      s.pan_position = pick(-32768, 32768);
      s.master_gain  = pick(0, 32768);
      return s;
   endfunction

   task automatic run_traffic(input int count);
      int          stop, r, win;
      logic [15:0] addr;
      stop = beats_sent + count;
      while (beats_sent < stop) begin
         r = int'($urandom_range(0, 99));
         if (r < 60) begin
            send_tick(draw_word(), draw_word());
         end else if (r < 85) begin
            win = (sb.sound_length == 0) ? 63
                : (sb.sound_length > 65536) ? 65535 : int'(sb.sound_length) - 1;
            addr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, win));
            send_beat(MODE_LOAD, addr, draw_word(), 16'($urandom), 16'($urandom));
         end else if (r < 95) begin
            send_beat(MODE_RESTART, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         end else begin
            send_beat(MODE_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         end
      end
   endtask

   initial begin
      voice_setup_type s;
      sb = new();
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Empty sound after reset, an unused mode, then a few samples including the top address.
      send_tick(16'h8000, 16'h7FFF);
      send_beat(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_beat(MODE_LOAD, 16'd0, 16'h8000, 16'h0000, 16'h0000);
      send_beat(MODE_LOAD, 16'd1, 16'h7FFF, 16'hFFFF, 16'hFFFF);
      send_beat(MODE_LOAD, 16'd2, 16'h5555, 16'h0000, 16'h0000);
      send_beat(MODE_LOAD, 16'd3, 16'hAAAA, 16'h0000, 16'h0000);
      send_beat(MODE_LOAD, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000);

      // Quarter-step interpolation at full left with saturating accumulators.
      program_voice('{0, 0, 65536, 4, 'h4000, 65535, -32768, 32768});
      send_beat(MODE_RESTART, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_tick(16'h8000, 16'h7FFF);
      send_tick(16'h7FFF, 16'h8000);
      send_tick(16'h0000, 16'h0000);
      send_tick(16'h0064, 16'hFF9C);

      // A short loop that the read points and the position wrap around.
      program_voice('{1, 1, 3, 4, 'h18000, 32768, 32768, 16384});
      send_beat(MODE_RESTART, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      repeat (4) send_tick(draw_word(), draw_word());

      // An empty loop region is ignored and an oversized sound length saturates.
      program_voice('{1, 3, 2, 'h1FFFF, 'h80000, 0, 0, 0});
      send_beat(MODE_RESTART, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      repeat (2) send_tick(draw_word(), draw_word());

      // A pitch step of eight samples runs a two-sample sound to its end within one tick.
      program_voice('{0, 0, 65536, 2, 'h80000, 40000, 12345, 32768});
      send_beat(MODE_RESTART, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      repeat (2) send_tick(draw_word(), draw_word());

      repeat (12) begin
         s = draw_setup();
         program_voice(s);
         quiet = ($urandom_range(0, 3) == 0);
         run_traffic(160);
      end

      settle();
      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
